[design/rhc_pkg.sv]
package rhc_pkg;

   // hue scale: degrees with six fractional bits
   localparam int HueSixth     = 3840;
   localparam int HueThird     = 7680;
   localparam int HueTwoThirds = 15360;
   localparam int HueTurn      = 23040;

   localparam int ChanWidth    = 8;
   localparam int HueWidth     = 15;
   localparam int SatWidth     = 9;

   // quotient bits of the two dividers and the stages they are spread over
   localparam int HueQuotWidth = 12;
   localparam int SatQuotWidth = 9;
   localparam int DivStages    = 3;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [ChanWidth-1:0] red_in;
      logic [ChanWidth-1:0] green_in;
      logic [ChanWidth-1:0] blue_in;
   } pixel_type;

   typedef struct packed {
      logic [HueWidth-1:0]  hue_out;
      logic [SatWidth-1:0]  sat_out;
      logic [ChanWidth-1:0] value_out;
   } hsv_type;

   // one pixel in flight: partial remainders, shift words and side info
   typedef struct packed {
      logic [ChanWidth-1:0]    hue_rem;
      logic [HueQuotWidth-1:0] hue_work;
      logic [ChanWidth-1:0]    hue_div;
      logic [ChanWidth-1:0]    sat_rem;
      logic [SatQuotWidth-1:0] sat_work;
      sector_type              sector;
      logic                    hue_neg;
      logic                    hue_zero;
      logic                    sat_zero;
      logic [ChanWidth-1:0]    value;
   } work_type;

endpackage

[design/rhc_stream_if.sv]
interface rhc_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/rhc_front.sv]
module rhc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rhc_pkg::pixel_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rhc_pkg::work_type out_data
);
   import rhc_pkg::*;

   logic                 valid_ff;
   work_type             data_ff;
   work_type             data_in;
   logic [ChanWidth-1:0] red, green, blue;
   logic [ChanWidth-1:0] max_val, min_val, delta;
   logic [ChanWidth-1:0] minuend, subtrahend, mag;
   logic [19:0]          hue_num;
   sector_type           sector;

   assign red   = in_data.red_in;
   assign green = in_data.green_in;
   assign blue  = in_data.blue_in;

   // ties go to red, then green
   always_comb begin
      if (red >= green && red >= blue) begin
         sector     = SECTOR_RED;
         max_val    = red;
         minuend    = green;
         subtrahend = blue;
      end else if (green >= blue) begin
         sector     = SECTOR_GREEN;
         max_val    = green;
         minuend    = blue;
         subtrahend = red;
      end else begin
         sector     = SECTOR_BLUE;
         max_val    = blue;
         minuend    = red;
         subtrahend = green;
      end
   end

   always_comb begin
      min_val = red;
      if (green < min_val) begin
         min_val = green;
      end
      if (blue < min_val) begin
         min_val = blue;
      end
   end

   assign delta = max_val - min_val;
   assign mag   = (minuend < subtrahend) ? (subtrahend - minuend) : (minuend - subtrahend);
   // times 3840 as 4096 - 256
   assign hue_num = {mag, 12'b0} - {4'b0, mag, 8'b0};

   always_comb begin
      data_in          = '0;
      data_in.hue_rem  = hue_num[19:HueQuotWidth];
      data_in.hue_work = hue_num[HueQuotWidth-1:0];
      data_in.hue_div  = delta;
      data_in.sat_rem  = {1'b0, delta[ChanWidth-1:1]};
      data_in.sat_work = {delta[0], {(SatQuotWidth-1){1'b0}}};
      data_in.sector   = sector;
      data_in.hue_neg  = minuend < subtrahend;
      data_in.hue_zero = delta == '0;
      data_in.sat_zero = max_val == '0;
      data_in.value    = max_val;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

[design/rhc_div_pipe.sv]
module rhc_div_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rhc_pkg::work_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rhc_pkg::work_type out_data
);
   import rhc_pkg::*;

   localparam int HueStepBits = HueQuotWidth / DivStages;
   localparam int SatStepBits = SatQuotWidth / DivStages;

   // one restoring step: returns quotient bit and new remainder
   function automatic logic [ChanWidth:0] div_bit(
      input logic [ChanWidth-1:0] rem,
      input logic                 nbit,
      input logic [ChanWidth-1:0] dv
   );
      logic [ChanWidth:0] trial;
      logic [ChanWidth:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, dv};
      if (trial >= {1'b0, dv}) begin
         return {1'b1, diff[ChanWidth-1:0]};
      end
      return {1'b0, trial[ChanWidth-1:0]};
   endfunction

   logic [DivStages-1:0] valid_ff;
   logic [DivStages-1:0] src_valid;
   logic [DivStages:0]   stage_ready;
   work_type             stage_ff  [DivStages];
   work_type             stage_in  [DivStages];
   work_type             stage_src [DivStages];

   assign stage_ready[DivStages] = out_ready;

   for (genvar s = 0; s < DivStages; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign stage_src[s] = in_data;
         assign src_valid[s] = in_valid;
      end else begin : g_rest
         assign stage_src[s] = stage_ff[s-1];
         assign src_valid[s] = valid_ff[s-1];
      end

      always_comb begin
         work_type w;
         logic     qb;
         w  = stage_src[s];
         qb = 1'b0;
         for (int i = 0; i < HueStepBits; i++) begin
            {qb, w.hue_rem} = div_bit(w.hue_rem, w.hue_work[HueQuotWidth-1], w.hue_div);
            w.hue_work      = {w.hue_work[HueQuotWidth-2:0], qb};
         end
         for (int i = 0; i < SatStepBits; i++) begin
            {qb, w.sat_rem} = div_bit(w.sat_rem, w.sat_work[SatQuotWidth-1], w.value);
            w.sat_work      = {w.sat_work[SatQuotWidth-2:0], qb};
         end
         stage_in[s] = w;
      end

      assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff[s] <= src_valid[s];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[s] && src_valid[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[DivStages-1];
   assign out_data  = stage_ff[DivStages-1];
endmodule

[design/rhc_back.sv]
module rhc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rhc_pkg::work_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rhc_pkg::hsv_type out_data
);
   import rhc_pkg::*;

   logic                 valid_ff;
   hsv_type              data_ff;
   hsv_type              data_in;
   logic [HueWidth-1:0]  base;
   logic [HueWidth-1:0]  quot;

   assign quot = {{(HueWidth-HueQuotWidth){1'b0}}, in_data.hue_work};

   always_comb begin
      case (in_data.sector)
         SECTOR_GREEN: base = HueWidth'(HueThird);
         SECTOR_BLUE:  base = HueWidth'(HueTwoThirds);
         default:      base = '0;
      endcase
   end

   always_comb begin
      data_in           = '0;
      data_in.value_out = in_data.value;
      data_in.sat_out   = in_data.sat_zero ? '0 : in_data.sat_work;
      if (in_data.hue_zero) begin
         data_in.hue_out = '0;
      end else if (in_data.hue_neg) begin
         // wrap negative hue around one full turn
         data_in.hue_out = (base < quot) ? (HueWidth'(HueTurn) - quot) : (base - quot);
      end else begin
         data_in.hue_out = base + quot;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

[design/rgb_to_hsv_converter.sv]
// channel      dir  payload                               beat when
// req_stream   in   red_in, green_in, blue_in (8b each)   valid && ready
// rsp_stream   out  hue_out 15b, sat_out 9b, value_out 8b valid && ready
//
// one pixel per clock sustained while rsp_stream is ready
// request to result: one compare stage, three divider stages, one assembly/output stage
// the divider stages set the depth: four hue and three saturation quotient bits each
// reset (synchronous) empties every stage; no clearing pass, no stored tables
// each stage has its own valid bit and holds while the next is full, so bubbles close up
// and a stall loses and repeats nothing
module rgb_to_hsv_converter (
   input logic         clock,
   input logic         reset,
   rhc_stream_if.sink   req_stream,
   rhc_stream_if.source rsp_stream
);
   import rhc_pkg::*;

   // front to divider
   logic     front_valid;
   logic     front_ready;
   work_type front_data;

   // divider to back end
   logic     div_valid;
   logic     div_ready;
   work_type div_data;

   pixel_type pixel;
   hsv_type   result;

   assign pixel = req_stream.payload;

   // max/min search, sector pick, hue numerator and saturation dividend
   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_stream.valid),
      .in_ready  (req_stream.ready),
      .in_data   (pixel),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // both restoring dividers side by side, hue 3840*diff/delta and sat 256*delta/max
   rhc_div_pipe u_div_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   // sector offset, sign, wraparound and output register
   rhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_stream.valid),
      .out_ready (rsp_stream.ready),
      .out_data  (result)
   );

   assign rsp_stream.payload = result;

`ifndef ASSERT_OFF
   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_stream.valid |-> result.hue_out < HueWidth'(HueTurn))
      else $error("hue out of range");

   a_sat_range : assert property (@(posedge clock) disable iff (reset)
      rsp_stream.valid |-> result.sat_out <= SatWidth'(256))
      else $error("saturation above one");

   a_black : assert property (@(posedge clock) disable iff (reset)
      (rsp_stream.valid && result.value_out == '0) |->
         (result.sat_out == '0 && result.hue_out == '0))
      else $error("black pixel with hue or saturation");

   a_gray : assert property (@(posedge clock) disable iff (reset)
      (rsp_stream.valid && result.sat_out == '0) |-> result.hue_out == '0)
      else $error("gray pixel with nonzero hue");
`endif
endmodule
